@@ hw/rtl/ldd_pkg.sv @@
`timescale 1ns / 1ps

package ldd_pkg;

  localparam int NUMBER_WIDTH_DEF = 31;
  localparam int YEAR_OUT_W       = 31;

  localparam logic [YEAR_OUT_W-1:0] YEAR_OUT_MAX = '1;

  // request kinds
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // result status codes
  localparam logic [1:0] STATUS_VALID   = 2'd0;
  localparam logic [1:0] STATUS_FORMAT  = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // days per month, entries past December read as zero (no such month)
  localparam logic [4:0] MONTH_DAYS [0:15] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  // days in a common year before the first of each month
  localparam logic [8:0] DAYS_BEFORE [0:15] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
  };

  // line summary handed from the scanner to the date checker
  typedef struct packed {
    logic                  emit;
    logic                  full;
    logic [YEAR_OUT_W-1:0] year;
    logic [8:0]            year_mod400;
    logic [3:0]            month;
    logic [5:0]            day;
  } ldd_line_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [YEAR_OUT_W-1:0] year;
    logic [3:0]            month;
    logic [4:0]            day;
    logic [8:0]            ordinal;
  } ldd_result_t;

  // v < 4000: subtract the largest multiple of 400 not above v
  function automatic logic [8:0] mod400_reduce(input logic [11:0] v);
    logic [11:0] r;
    r = v;
    for (int k = 1; k < 10; k++) begin
      if (v >= 12'(k * 400)) begin
        r = v - 12'(k * 400);
      end
    end
    return r[8:0];
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    d = MONTH_DAYS[m];
    if (m == 4'd2 && leap) begin
      d = 5'd29;
    end
    return d;
  endfunction

endpackage

@@ hw/rtl/ldd_if.sv @@
`timescale 1ns / 1ps

interface ldd_char_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

interface ldd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [30:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [8:0]  ordinal_day;

  modport source (output valid, output status, output year_out, output month_out,
                  output day_out, output ordinal_day, input ready);
  modport sink   (input valid, input status, input year_out, input month_out,
                  input day_out, input ordinal_day, output ready);
endinterface

@@ hw/rtl/ldd_scan.sv @@
`timescale 1ns / 1ps

module ldd_scan #(
  parameter int NUMBER_WIDTH = ldd_pkg::NUMBER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              op,
  input  logic [7:0]        ch,
  output ldd_pkg::ldd_line_t line
);
  import ldd_pkg::*;

  localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = '1;

  logic                    line_nonempty;
  logic                    in_digits;
  logic [1:0]              number_count;
  logic [NUMBER_WIDTH-1:0] accumulator;
  logic [8:0]              accumulator_mod400;
  logic [NUMBER_WIDTH-1:0] year_value;
  logic [8:0]              year_mod400;
  logic [3:0]              month_value;
  logic [5:0]              day_value;

  logic                    is_digit;
  logic [3:0]              dig;
  logic [NUMBER_WIDTH+3:0] acc_times;
  logic                    acc_sat;
  logic [NUMBER_WIDTH-1:0] acc_take;
  logic [11:0]             mod_times;
  logic [8:0]              mod_take;

  logic                    do_finish;
  logic [NUMBER_WIDTH-1:0] fin_year;
  logic [8:0]              fin_ym;
  logic [3:0]              fin_month;
  logic [5:0]              fin_day;
  logic [1:0]              fin_count;
  logic [3:0]              acc_month;
  logic [5:0]              acc_day;

  assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  assign dig      = ch[3:0];  // low nibble of '0'..'9' is the digit

  // acc*10 + digit, checked against the saturation limit
  assign acc_times = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0}
                   + {{NUMBER_WIDTH{1'b0}}, dig};
  assign acc_sat   = acc_times > {4'b0000, NUM_MAX};
  assign acc_take  = !in_digits ? {{(NUMBER_WIDTH-4){1'b0}}, dig} :
                     acc_sat    ? NUM_MAX : acc_times[NUMBER_WIDTH-1:0];

  // residue follows the exact digit string
  assign mod_times = {accumulator_mod400, 3'b000} + {2'b00, accumulator_mod400, 1'b0}
                   + {8'h00, dig};
  assign mod_take  = in_digits ? mod400_reduce(mod_times) : {5'b00000, dig};

  assign acc_month = (accumulator > NUMBER_WIDTH'(15)) ? 4'hF : accumulator[3:0];
  assign acc_day   = (accumulator > NUMBER_WIDTH'(63)) ? 6'h3F : accumulator[5:0];

  // a number ends on a separator or at end of line
  assign do_finish = in_digits && ((op == OP_EOL) || !is_digit);

  always_comb begin
    fin_year  = year_value;
    fin_ym    = year_mod400;
    fin_month = month_value;
    fin_day   = day_value;
    fin_count = number_count;
    if (do_finish) begin
      case (number_count)
        2'd0: begin
          fin_year = accumulator;
          fin_ym   = accumulator_mod400;
        end
        2'd1: fin_month = acc_month;
        2'd2: fin_day   = acc_day;
        default: ;
      endcase
      if (number_count != 2'd3) begin
        fin_count = number_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && (op == OP_EOL))) begin
      line_nonempty      <= 1'b0;
      in_digits          <= 1'b0;
      number_count       <= 2'd0;
      accumulator        <= '0;
      accumulator_mod400 <= '0;
      year_value         <= '0;
      year_mod400        <= '0;
      month_value        <= '0;
      day_value          <= '0;
    end else if (step) begin
      line_nonempty <= 1'b1;
      if (is_digit) begin
        accumulator        <= acc_take;
        accumulator_mod400 <= mod_take;
        in_digits          <= 1'b1;
      end else begin
        in_digits    <= 1'b0;
        year_value   <= fin_year;
        year_mod400  <= fin_ym;
        month_value  <= fin_month;
        day_value    <= fin_day;
        number_count <= fin_count;
      end
    end
  end

  generate
    if (NUMBER_WIDTH > YEAR_OUT_W) begin : g_year_wide
      assign line.year = (fin_year > {{(NUMBER_WIDTH-YEAR_OUT_W){1'b0}}, YEAR_OUT_MAX}) ?
                         YEAR_OUT_MAX : fin_year[YEAR_OUT_W-1:0];
    end else if (NUMBER_WIDTH == YEAR_OUT_W) begin : g_year_same
      assign line.year = fin_year;
    end else begin : g_year_narrow
      assign line.year = {{(YEAR_OUT_W-NUMBER_WIDTH){1'b0}}, fin_year};
    end
  endgenerate

  assign line.emit        = (op == OP_EOL) && line_nonempty;
  assign line.full        = (fin_count == 2'd3);
  assign line.year_mod400 = fin_ym;
  assign line.month       = fin_month;
  assign line.day         = fin_day;

endmodule

@@ hw/rtl/ldd_eval.sv @@
`timescale 1ns / 1ps

module ldd_eval (
  input  ldd_pkg::ldd_line_t   line,
  output ldd_pkg::ldd_result_t res
);
  import ldd_pkg::*;

  logic       leap;
  logic [4:0] dim;
  logic       date_ok;
  logic [8:0] ordinal;

  assign leap = (line.year_mod400 == 9'd0) ||
                ((line.year_mod400[1:0] == 2'b00) && (line.year_mod400 != 9'd100) &&
                 (line.year_mod400 != 9'd200) && (line.year_mod400 != 9'd300));

  assign dim     = month_length(line.month, leap);
  assign date_ok = (dim != 5'd0) && (line.day != 6'd0) && (line.day <= {1'b0, dim});
  assign ordinal = DAYS_BEFORE[line.month] + {8'h00, leap && (line.month > 4'd2)}
                 + {3'b000, line.day};

  always_comb begin
    res.year    = line.year;
    res.month   = '0;
    res.day     = '0;
    res.ordinal = '0;
    if (!line.full) begin
      res.status = STATUS_FORMAT;
    end else if (!date_ok) begin
      res.status = STATUS_INVALID;
    end else begin
      res.status  = STATUS_VALID;
      res.month   = line.month;
      res.day     = line.day[4:0];
      res.ordinal = ordinal;
    end
  end

endmodule

@@ hw/rtl/loose_date_day_of_year_top.sv @@
`timescale 1ns / 1ps

// Loose date scanner with Gregorian day of year.
// line_in carries one request per character (op = 0, byte on ch) or an end of
// line (op = 1). Each run of digits is a number; the first three are year,
// month and day. At end of a nonempty line one result leaves on date_out:
// status (valid, format problem, invalid date), the saturated year, and for a
// valid date month, day and day of year. An empty line gives no result.
// A request taken at line_in waits in the input register and is scanned into the
// result register when that register is free or being drained; a result shows
// on date_out from the result register.
// Throughput: one request per cycle while date_out is not stalled, set by the single
// scan/check stage that sits between the input register and the result register.
// Stall: while a result waits on date_out, one more request is still taken
// into the input register; after that line_in.ready drops until date_out is
// drained.
// Reset (rst, synchronous, active high) empties both registers and clears the
// line state; line_in.ready is high once reset has emptied the input register.
module loose_date_day_of_year_top #(
  parameter int NUMBER_WIDTH = ldd_pkg::NUMBER_WIDTH_DEF
) (
  input logic           clk,
  input logic           rst,
  ldd_char_if.sink      line_in,
  ldd_result_if.source  date_out
);
  import ldd_pkg::*;

  // input register
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_ch;

  // result register
  logic        out_valid;
  ldd_result_t out_res;

  ldd_line_t   line;
  ldd_result_t res;
  logic        advance;
  logic        in_take;

  // the scan stage moves whenever it holds a request and the result register is free or being drained
  assign advance = s1_valid && (!out_valid || date_out.ready);
  assign in_take = line_in.valid && line_in.ready;

  assign line_in.ready = !s1_valid || !out_valid || date_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (line_in.ready) begin
      s1_valid <= line_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op <= line_in.op;
      s1_ch <= line_in.ch;
    end
  end

  // running line state: digits, numbers, year residue
  ldd_scan #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .op   (s1_op),
    .ch   (s1_ch),
    .line (line)
  );

  // month/day range check and ordinal day
  ldd_eval u_eval (
    .line (line),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && line.emit) begin
      out_valid <= 1'b1;
    end else if (date_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && line.emit) begin
      out_res <= res;
    end
  end

  assign date_out.valid       = out_valid;
  assign date_out.status      = out_res.status;
  assign date_out.year_out    = out_res.year;
  assign date_out.month_out   = out_res.month;
  assign date_out.day_out     = out_res.day;
  assign date_out.ordinal_day = out_res.ordinal;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the loose date scanner.
// A short table of hand-picked lines runs first, then random lines, mostly
// well-formed dates with random content plus some noise and broken lines.
// Every accepted request goes through a scan model kept in this bench.
// Each result leaving date_out is checked against the oldest pending date.
module testbench;
  import ldd_pkg::*;

  typedef logic [7:0] line_t[$];

  // one row of the directed table; typed rows carry their own expected date
  typedef struct {
    string       text;
    bit          typed;
    ldd_result_t want;
  } date_row_t;

  localparam longint unsigned NUM_LIMIT = 64'h7FFF_FFFF;
  localparam int unsigned MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int RANDOM_REQUESTS = 1610;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ldd_char_if   line_in ();
  ldd_result_if date_out ();

  loose_date_day_of_year_top dut (
    .clk      (clk),
    .rst      (rst),
    .line_in  (line_in),
    .date_out (date_out)
  );

  always #4 clk = ~clk;

  // scan model state, cleared at each end of line
  bit              line_seen;
  bit              in_number;
  int unsigned     nums_done;
  longint unsigned num_val;
  int unsigned     num_mod;
  longint unsigned year_val;
  int unsigned     year_mod;
  int unsigned     month_val;
  int unsigned     day_val;

  ldd_result_t pending_dates[$];

  int  mismatches;
  int  requests;
  int  lines_sent;
  int  dates_checked;
  int  status_seen [3];
  bit  src_steady;
  bit  snk_steady;

  // '@' in a table row stands for a NUL byte
  date_row_t dir_rows [14] = '{
    // empty line straight out of reset: nothing comes back
    '{"", 1'b0, '0},
    // separators only
    '{"-", 1'b1, '{STATUS_FORMAT, 31'd0, 4'd0, 5'd0, 9'd0}},
    // two numbers
    '{"12 2", 1'b1, '{STATUS_FORMAT, 31'd12, 4'd0, 5'd0, 9'd0}},
    // leap by the 400 rule
    '{"2000/2/29", 1'b1, '{STATUS_VALID, 31'd2000, 4'd2, 5'd29, 9'd60}},
    // century, not leap
    '{"1900.2.29", 1'b1, '{STATUS_INVALID, 31'd1900, 4'd0, 5'd0, 9'd0}},
    '{"0 13 1", 1'b1, '{STATUS_INVALID, 31'd0, 4'd0, 5'd0, 9'd0}},
    // month zero, huge day, extra numbers after the third
    '{"4 0 99 7 8", 1'b1, '{STATUS_INVALID, 31'd4, 4'd0, 5'd0, 9'd0}},
    '{"7 1 64", 1'b1, '{STATUS_INVALID, 31'd7, 4'd0, 5'd0, 9'd0}},
    '{"1 1 0", 1'b1, '{STATUS_INVALID, 31'd1, 4'd0, 5'd0, 9'd0}},
    // saturated year, true residue 399 -> common year
    '{"99999999999 12 31", 1'b1, '{STATUS_VALID, YEAR_OUT_MAX, 4'd12, 5'd31, 9'd365}},
    // saturated year, true residue 0 -> leap
    '{"98765432101234561200 2 29", 1'b1,
      '{STATUS_VALID, YEAR_OUT_MAX, 4'd2, 5'd29, 9'd60}},
    // NUL and high bytes as separators
    '{"@1\3771\2001@", 1'b0, '0},
    '{"2024-12-31", 1'b0, '0},
    // largest year that fits exactly, leading zeros on month and day
    '{"2147483647 007 015", 1'b0, '0}
  };

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic void clear_scan();
    line_seen = 1'b0;
    in_number = 1'b0;
    nums_done = 0;
    num_val   = 0;
    num_mod   = 0;
    year_val  = 0;
    year_mod  = 0;
    month_val = 0;
    day_val   = 0;
  endfunction

  function automatic void close_number();
    case (nums_done)
      0: begin
        year_val = num_val;
        year_mod = num_mod;
      end
      1: month_val = (num_val > 15) ? 15 : int'(num_val);
      2: day_val = (num_val > 63) ? 63 : int'(num_val);
      default: ;
    endcase
    if (nums_done < 3) nums_done++;
    in_number = 1'b0;
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input bit leap);
    if (m < 1 || m > 12) return 0;
    if (m == 2 && leap) return 29;
    return MONTH_LEN[m];
  endfunction

  // advances the scan model by one request; returns 1 when a date comes out
  function automatic bit scan_date_request(input logic op, input logic [7:0] ch,
                                           output ldd_result_t res);
    int unsigned dig;
    int unsigned dim;
    int unsigned sum;
    bit          leap;
    res = '0;
    if (op == OP_CHAR) begin
      line_seen = 1'b1;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        dig = ch - CHAR_ZERO;
        if (!in_number) begin
          num_val   = dig;
          num_mod   = dig;
          in_number = 1'b1;
        end else begin
          if (num_val > (NUM_LIMIT - dig) / 10) num_val = NUM_LIMIT;
          else num_val = num_val * 10 + dig;
          num_mod = (num_mod * 10 + dig) % 400;
        end
      end else if (in_number) begin
        close_number();
      end
      return 1'b0;
    end
    if (in_number) close_number();
    if (!line_seen) begin
      clear_scan();
      return 1'b0;
    end
    res.status = STATUS_FORMAT;
    res.year   = year_val[30:0];
    if (nums_done == 3) begin
      leap = (year_mod == 0) || (year_mod % 4 == 0 && year_mod % 100 != 0);
      dim  = days_in(month_val, leap);
      if (dim == 0 || day_val < 1 || day_val > dim) begin
        res.status = STATUS_INVALID;
      end else begin
        sum = day_val;
        for (int m = 1; m < month_val; m++) sum += days_in(m, leap);
        res.status  = STATUS_VALID;
        res.month   = month_val[3:0];
        res.day     = day_val[4:0];
        res.ordinal = sum[8:0];
      end
    end
    clear_scan();
    return 1'b1;
  endfunction

  // one request on line_in; valid stays up across back-to-back requests
  task automatic push_request(input logic op, input logic [7:0] ch,
                              input bit use_typed, input ldd_result_t typed);
    int          gap;
    ldd_result_t res;
    gap = src_steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      line_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    line_in.valid <= 1'b1;
    line_in.op    <= op;
    line_in.ch    <= ch;
    do @(posedge clk); while (!line_in.ready);
    requests++;
    if (scan_date_request(op, ch, res))
      pending_dates.insert(pending_dates.size(), use_typed ? typed : res);
  endtask

  task automatic push_line(input line_t q, input bit use_typed, input ldd_result_t typed);
    foreach (q[i]) push_request(OP_CHAR, q[i], 1'b0, '0);
    // ch is don't-care on end of line, so it gets junk
    push_request(OP_EOL, 8'($urandom_range(0, 255)), use_typed, typed);
    lines_sent++;
  endtask

  function automatic logic [7:0] pick_separator();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = "-";
      1: b = "/";
      2: b = ".";
      3: b = " ";
      4: b = ":";
      5: b = ",";
      default: begin
        do b = 8'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
      end
    endcase
    return b;
  endfunction

  function automatic void put_number(ref line_t q, input longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) q.insert(q.size(), CHAR_ZERO);
    for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
  endfunction

  // mostly year/month/day with random content; some noise and short lines
  function automatic void build_line(ref line_t q);
    int              shape;
    int              nums;
    bit              long_year;
    longint unsigned vals [5];
    q.delete();
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      repeat ($urandom_range(0, 12)) q.insert(q.size(), 8'($urandom_range(0, 255)));
      return;
    end
    nums = (shape == 1) ? $urandom_range(0, 2) :
           3 + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
    long_year = 1'b0;
    case ($urandom_range(0, 9))
      0: long_year = 1'b1;
      1: vals[0] = $urandom;
      2, 3: vals[0] = $urandom_range(0, 24) * 100;
      default: vals[0] = $urandom_range(0, 2400);
    endcase
    vals[1] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0: vals[2] = $urandom_range(0, 99);
      1, 2, 3: vals[2] = $urandom_range(28, 32);   // around month end
      default: vals[2] = $urandom_range(1, 31);
    endcase
    vals[3] = $urandom_range(0, 99999);
    vals[4] = $urandom_range(0, 9);
    if ($urandom_range(0, 4) == 0) q.insert(q.size(), pick_separator());
    for (int k = 0; k < nums; k++) begin
      if (k > 0) repeat ($urandom_range(1, 2)) q.insert(q.size(), pick_separator());
      if (k == 0 && long_year) repeat ($urandom_range(10, 24))
        q.insert(q.size(), CHAR_ZERO + 8'($urandom_range(0, 9)));
      else put_number(q, vals[k]);
    end
    if ($urandom_range(0, 3) == 0) q.insert(q.size(), pick_separator());
  endfunction

  // stimulus and end of run
  initial begin
    line_t q;
    int    base;
    int    settle;
    line_in.valid <= 1'b0;
    line_in.op    <= OP_CHAR;
    line_in.ch    <= 8'h00;
    clear_scan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      q.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++)
        q.insert(q.size(), (dir_rows[r].text[i] == "@") ? 8'h00 : dir_rows[r].text[i]);
      push_line(q, dir_rows[r].typed, dir_rows[r].want);
    end

    base = requests;
    while (requests - base < RANDOM_REQUESTS) begin
      // now and then a line with no idling on one side or both
      src_steady = ($urandom_range(0, 5) == 0);
      snk_steady = ($urandom_range(0, 5) == 0);
      build_line(q);
      push_line(q, 1'b0, '0);
    end
    line_in.valid <= 1'b0;

    settle = 0;
    while (pending_dates.size() != 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    // give a stray result time to show up
    repeat (8) @(posedge clk);
    if (pending_dates.size() != 0)
      flag_mismatch($sformatf("%0d expected dates never arrived", pending_dates.size()));

    $display("Ran %0d lines in %0d requests; %0d dates checked", lines_sent, requests,
             dates_checked);
    $display("  by status: valid %0d, format problem %0d, invalid %0d",
             status_seen[0], status_seen[1], status_seen[2]);
    if (mismatches == 0) begin
      $display("loose_date_day_of_year_top: match");
    end else begin
      $display("loose_date_day_of_year_top: mismatch");
    end
    $finish;
  end

  // result side: random stalls, compare each date with the oldest pending one
  initial begin
    int          stall;
    ldd_result_t got;
    ldd_result_t want;
    date_out.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = snk_steady ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        date_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      date_out.ready <= 1'b1;
      do @(posedge clk); while (!date_out.valid);
      got = '{date_out.status, date_out.year_out, date_out.month_out,
              date_out.day_out, date_out.ordinal_day};
      dates_checked++;
      if (got.status <= STATUS_INVALID) status_seen[got.status]++;
      if (pending_dates.size() == 0) begin
        flag_mismatch($sformatf("date with none pending: status %0d year %0d",
                                got.status, got.year));
      end else begin
        want = pending_dates.pop_front();
        if (got !== want)
          flag_mismatch($sformatf({"date got st %0d y %0d m %0d d %0d ord %0d, ",
                                   "want st %0d y %0d m %0d d %0d ord %0d"},
                                  got.status, got.year, got.month, got.day, got.ordinal,
                                  want.status, want.year, want.month, want.day,
                                  want.ordinal));
      end
    end
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout: %0d dates still pending", pending_dates.size());
    $display("loose_date_day_of_year_top: mismatch");
    $finish;
  end

endmodule
